// ===== rtl/fprgba_pkg.sv =====
`timescale 1ns / 1ps

package fprgba_pkg;

  typedef enum logic [1:0] {
    MODE_RGBA8   = 2'd0,
    MODE_GREY    = 2'd1,
    MODE_RGBA32F = 2'd2,
    MODE_RGBA16F = 2'd3
  } src_mode_e;

  localparam logic [1:0] CFG_SOURCE_MODE = 2'd0;
  localparam logic [1:0] CFG_RANGE_LOW   = 2'd1;
  localparam logic [1:0] CFG_RANGE_HIGH  = 2'd2;

  localparam logic [31:0] RANGE_LOW_RST  = 32'h0000_0000;
  localparam logic [31:0] RANGE_HIGH_RST = 32'h3F80_0000;
  localparam logic [31:0] F32_ONE        = 32'h3F80_0000;
  localparam logic [31:0] F32_INF        = 32'h7F80_0000;
  localparam logic [31:0] F32_QNAN       = 32'h7FC0_0000;
  // Single precision bits of 1e-8; only spans above it are used as is.
  localparam logic [31:0] SPAN_MIN       = 32'h322B_CC77;

  localparam int NumStages = 21;
  localparam int DivStages = 13;
  localparam int DivFirst  = 4;

  typedef enum logic [1:0] {
    Q_ZERO = 2'd0,
    Q_BIG  = 2'd1,
    Q_DIV  = 2'd2
  } q_class_e;

  typedef logic [3:0][31:0] pix_t;

  typedef struct packed {
    logic        special;
    logic [31:0] spec_bits;
    logic        sign;
    logic [7:0]  exp;
    logic        eff_sub;
    logic [27:0] big;
    logic [27:0] sml;
  } add_a_t;

  typedef struct packed {
    logic        special;
    logic [31:0] spec_bits;
    logic        sign;
    logic [7:0]  exp;
    logic [27:0] sum;
  } add_b_t;

  typedef struct packed {
    add_b_t     b;
    logic [4:0] lz;
  } add_c_t;

  typedef struct packed {
    q_class_e          cls;
    logic signed [9:0] exp;
    logic [23:0]       ms;
    logic [24:0]       rem;
    logic [25:0]       quo;
    pix_t              pix;
  } div_t;

  typedef struct packed {
    logic        force_byte;
    logic [7:0]  fbyte;
    logic [40:0] fix;
  } lane_t;

  // First step of a - b: special operands, operand swap and alignment.
  function automatic add_a_t fsub_align(logic [31:0] a, logic [31:0] b);
    logic        sa, sb, nan_a, nan_b, inf_a, inf_b, swap, sl, ss;
    logic [7:0]  ea, eb, el, es, diff;
    logic [23:0] ma, mb, ml, msm;
    logic [53:0] wide;
    add_a_t      r;
    sa    = a[31];
    sb    = ~b[31];
    ea    = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma    = {a[30:23] != 8'd0, a[22:0]};
    mb    = {b[30:23] != 8'd0, b[22:0]};
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    r.special   = 1'b0;
    r.spec_bits = F32_QNAN;
    if (nan_a || nan_b) begin
      r.special = 1'b1;
    end else if (inf_a && inf_b) begin
      r.special   = 1'b1;
      r.spec_bits = (sa != sb) ? F32_QNAN : {sa, F32_INF[30:0]};
    end else if (inf_a) begin
      r.special   = 1'b1;
      r.spec_bits = {sa, F32_INF[30:0]};
    end else if (inf_b) begin
      r.special   = 1'b1;
      r.spec_bits = {sb, F32_INF[30:0]};
    end
    swap = {ea, ma} < {eb, mb};
    el   = swap ? eb : ea;
    es   = swap ? ea : eb;
    ml   = swap ? mb : ma;
    msm  = swap ? ma : mb;
    sl   = swap ? sb : sa;
    ss   = swap ? sa : sb;
    diff = el - es;
    wide = {msm, 3'b000, 27'd0} >> diff;
    r.sml = {1'b0, wide[53:28], wide[27] | (|wide[26:0])};
    if (diff > 8'd26) begin
      r.sml = {27'd0, msm != 24'd0};
    end
    r.big     = {1'b0, ml, 3'b000};
    r.sign    = sl;
    r.exp     = el;
    r.eff_sub = sl ^ ss;
    return r;
  endfunction

  function automatic add_b_t fsub_add(add_a_t a);
    add_b_t r;
    r.special   = a.special;
    r.spec_bits = a.spec_bits;
    r.sign      = a.sign;
    r.exp       = a.exp;
    r.sum       = a.eff_sub ? (a.big - a.sml) : (a.big + a.sml);
    return r;
  endfunction

  function automatic logic [4:0] lzc27(logic [26:0] x);
    logic [4:0] lz;
    lz = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (x[i]) begin
        lz = 5'(26 - i);
      end
    end
    return lz;
  endfunction

  // Normalize and round to nearest even. Results below the normal range flush to zero.
  function automatic logic [31:0] fsub_round(add_c_t c);
    logic [26:0]       nrm;
    logic signed [9:0] e;
    logic [24:0]       m;
    logic              up;
    if (c.b.special) begin
      return c.b.spec_bits;
    end
    if (c.b.sum == 28'd0) begin
      return 32'd0;
    end
    if (c.b.sum[27]) begin
      nrm = {c.b.sum[27:2], c.b.sum[1] | c.b.sum[0]};
      e   = $signed({2'b00, c.b.exp}) + 10'sd1;
    end else begin
      nrm = c.b.sum[26:0] << c.lz;
      e   = $signed({2'b00, c.b.exp}) - $signed({5'd0, c.lz});
    end
    up = nrm[2] & (nrm[1] | nrm[0] | nrm[3]);
    m  = {1'b0, nrm[26:3]} + {24'd0, up};
    if (m[24]) begin
      e = e + 10'sd1;
    end
    if (e < 10'sd1) begin
      return {c.b.sign, 31'd0};
    end
    if (e > 10'sd254) begin
      return {c.b.sign, F32_INF[30:0]};
    end
    return {c.b.sign, e[7:0], m[22:0]};
  endfunction

  function automatic div_t div_setup(logic [31:0] d, logic [31:0] n, pix_t pix);
    logic        span_ok, n_nan, n_inf, s_inf;
    logic [31:0] span;
    logic [23:0] mn;
    div_t        r;
    span_ok = !d[31] && (d[30:0] > SPAN_MIN[30:0]) &&
              !((d[30:23] == 8'hFF) && (d[22:0] != 23'd0));
    span    = span_ok ? d : F32_ONE;
    n_nan   = (n[30:23] == 8'hFF) && (n[22:0] != 23'd0);
    n_inf   = (n[30:23] == 8'hFF) && (n[22:0] == 23'd0);
    s_inf   = span[30:23] == 8'hFF;
    if (n_nan || n[31] || (n[30:23] == 8'd0)) begin
      r.cls = Q_ZERO;
    end else if (n_inf) begin
      r.cls = s_inf ? Q_ZERO : Q_BIG;
    end else if (s_inf) begin
      r.cls = Q_ZERO;
    end else begin
      r.cls = Q_DIV;
    end
    mn    = {1'b1, n[22:0]};
    r.ms  = {1'b1, span[22:0]};
    r.exp = $signed({2'b00, n[30:23]}) - $signed({2'b00, span[30:23]}) + 10'sd127;
    if (mn < r.ms) begin
      r.exp = r.exp - 10'sd1;
      r.rem = {mn, 1'b0};
    end else begin
      r.rem = {1'b0, mn};
    end
    r.quo = 26'd0;
    r.pix = pix;
    return r;
  endfunction

  // Two restoring quotient bits.
  function automatic div_t div_step(div_t a);
    div_t r;
    logic q;
    r = a;
    for (int i = 0; i < 2; i++) begin
      q = r.rem >= {1'b0, r.ms};
      if (q) begin
        r.rem = r.rem - {1'b0, r.ms};
      end
      r.rem = {r.rem[23:0], 1'b0};
      r.quo = {r.quo[24:0], q};
    end
    return r;
  endfunction

  function automatic logic [31:0] div_round(div_t a);
    logic [24:0]       m;
    logic signed [9:0] e;
    logic              up;
    up = a.quo[1] & (a.quo[0] | (a.rem != 25'd0) | a.quo[2]);
    m  = {1'b0, a.quo[25:2]} + {24'd0, up};
    e  = a.exp;
    if (m[24]) begin
      e = e + 10'sd1;
    end
    case (a.cls)
      Q_BIG:   return F32_INF;
      Q_DIV: begin
        if (e > 10'sd254) begin
          return F32_INF;
        end
        if (e < 10'sd1) begin
          return 32'd0;
        end
        return {1'b0, e[7:0], m[22:0]};
      end
      default: return 32'd0;
    endcase
  endfunction

  // Clamp a single to 0..1 and form value * 255 with 31 fraction bits.
  function automatic lane_t conv_f32(logic [31:0] bits);
    logic [3:0]  sh;
    logic [31:0] m32;
    logic [40:0] x;
    lane_t       r;
    r.force_byte = 1'b1;
    r.fbyte      = 8'd0;
    r.fix        = 41'd0;
    if (bits[31] || ((bits[30:23] == 8'hFF) && (bits[22:0] != 23'd0))) begin
      r.fbyte = 8'd0;
    end else if (bits[30:0] > F32_ONE[30:0]) begin
      r.fbyte = 8'd255;
    end else if (bits[30:23] >= 8'd119) begin
      r.force_byte = 1'b0;
      sh    = 4'(bits[30:23] - 8'd119);
      m32   = {8'd0, 1'b1, bits[22:0]} << sh;
      x     = {9'd0, m32};
      r.fix = (x << 8) - x;
    end
    return r;
  endfunction

  // Clamp a half to 0..1 and form value * 255 + 0.5 with 31 fraction bits.
  function automatic lane_t conv_f16(logic [15:0] h);
    logic [24:0] vi;
    logic [40:0] x;
    lane_t       r;
    r.force_byte = 1'b1;
    r.fbyte      = 8'd0;
    r.fix        = 41'd0;
    if (h[14:10] == 5'h1F) begin
      if ((h[9:0] == 10'd0) && !h[15]) begin
        r.fbyte = 8'd255;
      end
    end else if (!h[15]) begin
      r.force_byte = 1'b0;
      if (h[14:10] == 5'd0) begin
        vi = {15'd0, h[9:0]};
      end else if ((h[14:10] > 5'd15) || ((h[14:10] == 5'd15) && (h[9:0] != 10'd0))) begin
        vi = 25'h100_0000;
      end else begin
        vi = {14'd0, 1'b1, h[9:0]} << (h[14:10] - 5'd1);
      end
      x     = {16'd0, vi};
      r.fix = ((x << 8) - x + 41'h80_0000) << 7;
    end
    return r;
  endfunction

  // Integer part of the value rounded to single precision, nearest even.
  function automatic logic [7:0] rnd_floor(logic [40:0] v);
    logic [4:0]  sh;
    logic [40:0] kept, mask, res;
    logic        up;
    if (v[40:31] == 10'd0) begin
      return (v[30:0] >= 31'h7FFF_FFC0) ? 8'd1 : 8'd0;
    end
    sh = 5'd8;
    for (int b = 31; b < 40; b++) begin
      if (v[b]) begin
        sh = 5'(b - 23);
      end
    end
    kept = v >> sh;
    mask = (41'd1 << (sh - 5'd1)) - 41'd1;
    up   = v[sh - 5'd1] & ((|(v & mask)) | kept[0]);
    res  = (kept + {40'd0, up}) << sh;
    return res[38:31];
  endfunction

endpackage

// ===== rtl/float_pixel_to_rgba8_display.sv =====
`timescale 1ns / 1ps

// Channel  Handshake                Word
// cfg      cfg_we_i                 cfg_index_i, cfg_data_i
// in       in_valid_i / in_ready_o  comp_red_i, comp_green_i, comp_blue_i, comp_alpha_i
// out      out_valid_o/out_ready_i  out_red_o, out_green_o, out_blue_o, out_alpha_o
//
// One word is accepted per cycle while in_ready_o is high.
// The pipeline holds two single subtractors, a divider that makes two quotient
// bits per stage and the final scale and round stages.
// Reset clears the valid bits and loads the register defaults.
// A stalled output holds the full stages at the end of the pipe; stages in front of an empty stage keep moving.
module float_pixel_to_rgba8_display (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] comp_red_i,
  input  logic [31:0] comp_green_i,
  input  logic [31:0] comp_blue_i,
  input  logic [31:0] comp_alpha_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_alpha_o
);

  localparam int NS = fprgba_pkg::NumStages;
  localparam int DS = fprgba_pkg::DivStages;
  localparam int DF = fprgba_pkg::DivFirst;

  fprgba_pkg::src_mode_e source_mode_q;
  logic [31:0]           range_low_q;
  logic [31:0]           range_high_q;

  logic [NS-1:0] valid_q;
  logic [NS-1:0] en;

  fprgba_pkg::pix_t   pix_in;
  fprgba_pkg::add_a_t d_a_q, n_a_q;
  fprgba_pkg::pix_t   pix0_q;
  fprgba_pkg::add_b_t d_b_q, n_b_q;
  fprgba_pkg::pix_t   pix1_q;
  fprgba_pkg::add_c_t d_c_q, n_c_q;
  fprgba_pkg::pix_t   pix2_q;
  logic [31:0]        d_bits_q, n_bits_q;
  fprgba_pkg::pix_t   pix3_q;
  fprgba_pkg::div_t   div_q [DS+1];
  logic [31:0]        qbits_q;
  fprgba_pkg::pix_t   pix_q_q;
  fprgba_pkg::lane_t  lane_d [4];
  fprgba_pkg::lane_t  lane_q [4];
  logic [7:0]         byte_q [4];

  assign pix_in = {comp_alpha_i, comp_blue_i, comp_green_i, comp_red_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_mode_q <= fprgba_pkg::MODE_RGBA8;
      range_low_q   <= fprgba_pkg::RANGE_LOW_RST;
      range_high_q  <= fprgba_pkg::RANGE_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fprgba_pkg::CFG_SOURCE_MODE: begin
          source_mode_q <= fprgba_pkg::src_mode_e'(cfg_data_i[1:0]);
        end
        fprgba_pkg::CFG_RANGE_LOW: begin
          range_low_q <= cfg_data_i;
        end
        fprgba_pkg::CFG_RANGE_HIGH: begin
          range_high_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    en[NS-1] = !valid_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      d_a_q  <= fprgba_pkg::fsub_align(range_high_q, range_low_q);
      n_a_q  <= fprgba_pkg::fsub_align(comp_red_i, range_low_q);
      pix0_q <= pix_in;
    end
    if (en[1]) begin
      d_b_q  <= fprgba_pkg::fsub_add(d_a_q);
      n_b_q  <= fprgba_pkg::fsub_add(n_a_q);
      pix1_q <= pix0_q;
    end
    if (en[2]) begin
      d_c_q.b  <= d_b_q;
      d_c_q.lz <= fprgba_pkg::lzc27(d_b_q.sum[26:0]);
      n_c_q.b  <= n_b_q;
      n_c_q.lz <= fprgba_pkg::lzc27(n_b_q.sum[26:0]);
      pix2_q   <= pix1_q;
    end
    if (en[3]) begin
      d_bits_q <= fprgba_pkg::fsub_round(d_c_q);
      n_bits_q <= fprgba_pkg::fsub_round(n_c_q);
      pix3_q   <= pix2_q;
    end
    if (en[DF]) begin
      div_q[0] <= fprgba_pkg::div_setup(d_bits_q, n_bits_q, pix3_q);
    end
  end

  for (genvar i = 1; i <= DS; i++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en[DF+i]) begin
        div_q[i] <= fprgba_pkg::div_step(div_q[i-1]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lane_d[k].force_byte = 1'b1;
      lane_d[k].fbyte      = pix_q_q[k][7:0];
      lane_d[k].fix        = 41'd0;
      case (source_mode_q)
        fprgba_pkg::MODE_GREY: begin
          if (k == 3) begin
            lane_d[k].fbyte = 8'd255;
          end else begin
            lane_d[k] = fprgba_pkg::conv_f32(qbits_q);
          end
        end
        fprgba_pkg::MODE_RGBA32F: begin
          lane_d[k] = fprgba_pkg::conv_f32(pix_q_q[k]);
        end
        fprgba_pkg::MODE_RGBA16F: begin
          lane_d[k] = fprgba_pkg::conv_f16(pix_q_q[k][15:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[DF+DS+1]) begin
      qbits_q <= fprgba_pkg::div_round(div_q[DS]);
      pix_q_q <= div_q[DS].pix;
    end
    if (en[DF+DS+2]) begin
      for (int k = 0; k < 4; k++) begin
        lane_q[k] <= lane_d[k];
      end
    end
    if (en[DF+DS+3]) begin
      for (int k = 0; k < 4; k++) begin
        byte_q[k] <= lane_q[k].force_byte ? lane_q[k].fbyte :
                     fprgba_pkg::rnd_floor(lane_q[k].fix);
      end
    end
  end

  assign out_valid_o = valid_q[NS-1];
  assign out_red_o   = byte_q[0];
  assign out_green_o = byte_q[1];
  assign out_blue_o  = byte_q[2];
  assign out_alpha_o = byte_q[3];

endmodule
